/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the point-mass acceleration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pmsa_pkg.sv */
// Types and fixed constants of the point-mass acceleration block.
`default_nettype none
package pmsa_pkg;

	localparam int ACC_W    = 48;
	localparam int OUT_FRAC = 24;
	localparam int GUARD    = 8;
	localparam int S_W      = 67;
	localparam int R_W      = 42;
	localparam int DEN_W    = 109;
	localparam int QUO_W    = 47;
	localparam int PROD_W   = 65;
	localparam int SPLIT_S  = 34;
	localparam int SPLIT_R  = 21;
	localparam int CFG_W    = 3;

	typedef enum logic [CFG_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_GM       = 3'd3,
		REG_SOFTEN   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pos_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_x;
		logic signed [ACC_W-1:0] acc_y;
		logic signed [ACC_W-1:0] acc_z;
		logic                    singular;
	} acc_t;

endpackage
`default_nettype wire

/* rtl/pmsa_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with the radicand passed along.
`default_nettype none
module pmsa_isqrt (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [pmsa_pkg::S_W-1:0]   s_in,
	output logic      [pmsa_pkg::R_W-1:0]   root,
	output logic      [pmsa_pkg::S_W-1:0]   s_out
);
	localparam int SW = pmsa_pkg::S_W;
	localparam int RW = pmsa_pkg::R_W;
	localparam int G2 = 2 * pmsa_pkg::GUARD;
	localparam int VW = SW + G2;
	localparam int TW = VW + 2;

	logic [VW-1:0] v_s   [RW];
	logic [RW-1:0] res_s [RW];
	logic [VW-1:0] sq_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic [VW-1:0] v_i;
		logic [RW-1:0] res_i;
		logic [VW-1:0] sq_i;
		logic [TW-1:0] trial;
		logic          fits;

		if (k == 0) begin : g_first
			assign v_i   = {s_in, {G2{1'b0}}};
			assign res_i = '0;
			assign sq_i  = '0;
		end else begin : g_next
			assign v_i   = v_s[k-1];
			assign res_i = res_s[k-1];
			assign sq_i  = sq_s[k-1];
		end

		// (res + 2^B)^2 = res^2 + res*2^(B+1) + 2^(2B)
		assign trial = TW'(sq_i) + (TW'(res_i) << (B + 1)) + (TW'(1) << (2 * B));
		assign fits  = trial <= TW'(v_i);

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k]   <= v_i;
				res_s[k] <= fits ? (res_i | (RW'(1) << B)) : res_i;
				sq_s[k]  <= fits ? VW'(trial) : sq_i;
			end
		end
	end

	assign root  = res_s[RW-1];
	assign s_out = v_s[RW-1][VW-1:G2];

endmodule
`default_nettype wire

/* rtl/pmsa_div.sv */
// Pipelined restoring divider with an overflow flag for quotients beyond the result width.
`default_nettype none
module pmsa_div #(
	parameter int NUM_W = 113
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [NUM_W-1:0]             num,
	input  wire logic [pmsa_pkg::DEN_W-1:0]   den,
	output logic      [pmsa_pkg::QUO_W-1:0]   quo,
	output logic                              ovf
);
	localparam int DW = pmsa_pkg::DEN_W;
	localparam int QW = pmsa_pkg::QUO_W;
	localparam int CW = DW + QW + 1;

	logic [NUM_W-1:0] rem_s [QW];
	logic [DW-1:0]    den_s [QW];
	logic [QW-1:0]    quo_s [QW];
	logic             ovf_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [NUM_W-1:0] rem_i;
		logic [DW-1:0]    den_i;
		logic [QW-1:0]    quo_i;
		logic             ovf_i;
		logic [CW-1:0]    rem_x;
		logic [CW-1:0]    den_x;
		logic             take;

		if (k == 0) begin : g_first
			// The quotient needs more than QW bits exactly when num >= den * 2^QW.
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
			assign ovf_i = CW'(num) >= (CW'(den) << QW);
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
			assign ovf_i = ovf_s[k-1];
		end

		assign rem_x = CW'(rem_i);
		assign den_x = CW'(den_i) << B;
		assign take  = rem_x >= den_x;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? NUM_W'(rem_x - den_x) : rem_i;
				den_s[k] <= den_i;
				quo_s[k] <= take ? (quo_i | (QW'(1) << B)) : quo_i;
				ovf_s[k] <= ovf_i;
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign ovf = ovf_s[QW-1];

endmodule
`default_nettype wire

/* rtl/point_mass_softened_acceleration.sv */
// An accepted position transaction passes through registered offset, magnitude, square, sum, root, denominator,
// divide and output stages to its acceleration result. Throughput: one transaction per cycle unless a held result
// stalls; the 42-stage square root and the 47-stage dividers are fully pipelined, so nothing in the path is shared.
// A stalled output freezes the whole pipeline in place; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults (center 0, GM 1.0, no softening).
`default_nettype none
module point_mass_softened_acceleration #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pos_valid,
	output logic                               pos_stall,
	input  wire pmsa_pkg::pos_t                pos_data,
	output logic                               acc_valid,
	input  wire logic                          acc_stall,
	output pmsa_pkg::acc_t                     acc_data,
	input  wire logic                          cfg_we,
	input  wire logic [pmsa_pkg::CFG_W-1:0]    cfg_index,
	input  wire logic [31:0]                   cfg_data
);
`include "assert_macros.svh"

	localparam int SW       = pmsa_pkg::S_W;
	localparam int RW       = pmsa_pkg::R_W;
	localparam int DW       = pmsa_pkg::DEN_W;
	localparam int QW       = pmsa_pkg::QUO_W;
	localparam int PW       = pmsa_pkg::PROD_W;
	localparam int AW       = pmsa_pkg::ACC_W;
	localparam int SS       = pmsa_pkg::SPLIT_S;
	localparam int SR       = pmsa_pkg::SPLIT_R;
	localparam int SHIFT    = FRAC_BITS + pmsa_pkg::OUT_FRAC + pmsa_pkg::GUARD;
	localparam int NUM_W    = PW + SHIFT;
	localparam int ST_SUM   = 4;
	localparam int ST_ROOT  = ST_SUM + RW;
	localparam int ST_DEN   = ST_ROOT + 2;
	localparam int ST_QUO   = ST_DEN + QW;
	localparam int VLAT     = ST_QUO + 1;

	// Per-item flags that ride alongside the arithmetic: which axes point away from the
	// center (those get a negative acceleration), which axes are nonzero, and the
	// singular case where the point sits on the center with no softening.
	typedef struct packed {
		logic [2:0] pos;
		logic [2:0] nz;
		logic       sing;
	} side_t;

	// Configuration registers; the user must write them only while the pipeline is empty; the block does not enforce it.
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic        [31:0] gm_q;
	logic        [30:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			gm_q  <= 32'h0001_0000;
			eps_q <= '0;
		end else if (cfg_we) begin
			case (pmsa_pkg::cfg_reg_t'(cfg_index))
				pmsa_pkg::REG_CENTER_X: cx_q  <= cfg_data;
				pmsa_pkg::REG_CENTER_Y: cy_q  <= cfg_data;
				pmsa_pkg::REG_CENTER_Z: cz_q  <= cfg_data;
				pmsa_pkg::REG_GM:       gm_q  <= cfg_data;
				pmsa_pkg::REG_SOFTEN:   eps_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances as one unit unless a finished result is being held.
	logic adv;
	logic [VLAT:1] valid_s;

	assign adv       = !(acc_valid && acc_stall);
	assign pos_stall = !adv;
	assign acc_valid = valid_s[VLAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[VLAT-1:1], pos_valid};
		end
	end

	logic signed [31:0] p_in  [3];
	logic signed [31:0] c_cfg [3];

	always_comb begin
		p_in[0]  = pos_data.pos_x;
		p_in[1]  = pos_data.pos_y;
		p_in[2]  = pos_data.pos_z;
		c_cfg[0] = cx_q;
		c_cfg[1] = cy_q;
		c_cfg[2] = cz_q;
	end

	// Stage 1: exact 33-bit offsets from the center.
	logic signed [32:0] d_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= 33'(p_in[k]) - 33'(c_cfg[k]);
			end
		end
	end

	// Stage 2: magnitudes and direction flags.
	logic [32:0] ad_s2 [3];
	logic [2:0]  pos_s2, nz_s2;
	logic        sing_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				ad_s2[k]  <= d_s1[k][32] ? 33'(-d_s1[k]) : 33'(d_s1[k]);
				pos_s2[k] <= !d_s1[k][32] && (d_s1[k] != '0);
				nz_s2[k]  <= d_s1[k] != '0;
			end
			sing_s2 <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0)
				&& (eps_q == '0);
		end
	end

	// Stage 3: squares for the radius and the GM * |d| numerators.
	logic [65:0]   sq_s3 [3];
	logic [61:0]   esq_s3;
	logic [PW-1:0] prod_s3 [3];
	side_t         side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sq_s3[k]   <= 66'(ad_s2[k]) * 66'(ad_s2[k]);
				prod_s3[k] <= PW'(gm_q) * PW'(ad_s2[k]);
			end
			esq_s3  <= 62'(eps_q) * 62'(eps_q);
			side_s3 <= '{pos: pos_s2, nz: nz_s2, sing: sing_s2};
		end
	end

	// Stage 4: s = |d|^2 + eps^2. Flags and numerators then wait for the root and divide.
	logic [SW-1:0] s_s4;
	side_t         side_s [ST_SUM:ST_QUO];
	logic [PW-1:0] prod_s [ST_SUM:ST_DEN][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]) + SW'(esq_s3);
			side_s[ST_SUM] <= side_s3;
			for (int i = ST_SUM + 1; i <= ST_QUO; i++) begin
				side_s[i] <= side_s[i-1];
			end
			for (int k = 0; k < 3; k++) begin
				prod_s[ST_SUM][k] <= prod_s3[k];
				for (int i = ST_SUM + 1; i <= ST_DEN; i++) begin
					prod_s[i][k] <= prod_s[i-1][k];
				end
			end
		end
	end

	// Square root of s with eight guard bits, one bit per stage.
	logic [RW-1:0] root_r;
	logic [SW-1:0] s_r;

	pmsa_isqrt u_isqrt (
		.clk   (clk),
		.en    (adv),
		.s_in  (s_s4),
		.root  (root_r),
		.s_out (s_r)
	);

	// Denominator s * R, split into four partial products and summed a stage later.
	logic [SS+SR-1:0]           pp0_s47, pp1_s47;
	logic [SW-SS+RW-SR-1:0]     pp2_s47, pp3_s47;
	logic [DW-1:0]              den_s48;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp0_s47 <= (SS+SR)'(s_r[SS-1:0]) * (SS+SR)'(root_r[SR-1:0]);
			pp1_s47 <= (SS+SR)'(s_r[SS-1:0]) * (SS+SR)'(root_r[RW-1:SR]);
			pp2_s47 <= (SW-SS+RW-SR)'(s_r[SW-1:SS]) * (SW-SS+RW-SR)'(root_r[SR-1:0]);
			pp3_s47 <= (SW-SS+RW-SR)'(s_r[SW-1:SS]) * (SW-SS+RW-SR)'(root_r[RW-1:SR]);
			den_s48 <= DW'(pp0_s47) + (DW'(pp1_s47) << SR) + (DW'(pp2_s47) << SS)
				+ (DW'(pp3_s47) << (SS + SR));
		end
	end

	// One divider per axis: |a| = GM * |d| * 2^SHIFT / (s * R).
	logic [QW-1:0] quo_r [3];
	logic          ovf_r [3];

	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic [NUM_W-1:0] num;

		assign num = NUM_W'(prod_s[ST_DEN][k]) << SHIFT;

		pmsa_div #(
			.NUM_W (NUM_W)
		) u_div (
			.clk (clk),
			.en  (adv),
			.num (num),
			.den (den_s48),
			.quo (quo_r[k]),
			.ovf (ovf_r[k])
		);
	end

	// Saturate, apply the sign opposite to d, zero axes with no offset, and clear everything at the singular point.
	logic [AW-1:0]  acc_c [3];
	pmsa_pkg::acc_t acc_q;
	side_t          side_o;

	assign side_o = side_s[ST_QUO];

	always_comb begin
		logic [AW-1:0] mag;
		for (int k = 0; k < 3; k++) begin
			mag = ovf_r[k] ? {1'b0, {(AW-1){1'b1}}} : AW'(quo_r[k]);
			if (!side_o.nz[k] || side_o.sing) begin
				acc_c[k] = '0;
			end else if (side_o.pos[k]) begin
				acc_c[k] = AW'(0) - mag;
			end else begin
				acc_c[k] = mag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q.acc_x    <= acc_c[0];
			acc_q.acc_y    <= acc_c[1];
			acc_q.acc_z    <= acc_c[2];
			acc_q.singular <= side_o.sing;
		end
	end

	assign acc_data = acc_q;

	`ASSERT_IMPLIES(a_sing_zero, clk, arst_n, acc_valid && acc_data.singular, (acc_data.acc_x == '0) && (acc_data.acc_y == '0) && (acc_data.acc_z == '0), "singular result carries a nonzero acceleration")
	`ASSERT_IMPLIES(a_sym_sat, clk, arst_n, acc_valid, (acc_data.acc_x != {1'b1, {(AW-1){1'b0}}}) && (acc_data.acc_y != {1'b1, {(AW-1){1'b0}}}) && (acc_data.acc_z != {1'b1, {(AW-1){1'b0}}}), "acceleration reached the asymmetric negative limit")
	`ASSERT_NEXT(a_accept_s1, clk, arst_n, pos_valid && !pos_stall, valid_s[1], "accepted transaction did not enter the pipeline")
	`ASSERT_NEXT(a_freeze, clk, arst_n, acc_valid && acc_stall, acc_valid && $stable(valid_s), "pipeline moved while the result was held")

endmodule
`default_nettype wire
